FILE: design/button_press_classifier_top_assert.svh
// Assertion helpers for the button press classifier.
// All checks are clocked on clk and held off while arst_n is low.
`ifndef BUTTON_PRESS_CLASSIFIER_TOP_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication.
`define BPC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication.
`define BPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

FILE: design/bpc_pkg.sv
package bpc_pkg;

	// Fixed field widths
	localparam int NOW_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int LAT_W      = 16;

	// Register indexes on the write port
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DOWN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACT_LOW   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_IRQ   = 2'd3;

	// Register reset values
	localparam logic [LAT_W-1:0] DEBOUNCE_RST  = 16'd50;
	localparam logic [LAT_W-1:0] HOLD_DOWN_RST = 16'd1000;

	// Button phases
	typedef enum logic [1:0] {
		PH_STANDBY   = 2'd0,
		PH_DETECTING = 2'd1,
		PH_WAITING   = 2'd2
	} phase_t;

	// Classification codes
	typedef enum logic [1:0] {
		RES_SKIP    = 2'd0,
		RES_PUSHING = 2'd1,
		RES_SHORT   = 2'd2,
		RES_LONG    = 2'd3
	} res_t;

	// Item function codes
	localparam logic FUNC_POLL = 1'b0;
	localparam logic FUNC_IRQ  = 1'b1;

	typedef struct packed {
		logic [LAT_W-1:0] debounce_latency;
		logic [LAT_W-1:0] hold_down_time;
		logic             active_low;
		logic             use_interrupt;
	} cfg_t;

	typedef struct packed {
		logic             func;
		logic             pin_level;
		logic [NOW_W-1:0] now_ms;
	} item_t;

	// Core status seen by the top level
	typedef struct packed {
		phase_t phase;
	} core_status_t;

endpackage

FILE: design/bpc_if.sv
// Input item channel
interface bpc_item_if import bpc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             func;
	logic             pin_level;
	logic [NOW_W-1:0] now_ms;

	modport source (output valid, output func, output pin_level, output now_ms, input ready);
	modport sink   (input valid, input func, input pin_level, input now_ms, output ready);
endinterface

// Result channel
interface bpc_result_if ();
	logic       valid;
	logic       ready;
	logic [1:0] press_result;

	modport source (output valid, output press_result, input ready);
	modport sink   (input valid, input press_result, output ready);
endinterface

FILE: design/bpc_cfg_regs.sv
module bpc_cfg_regs import bpc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Register file, writes masked to each register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_latency <= DEBOUNCE_RST;
			cfg_q.hold_down_time   <= HOLD_DOWN_RST;
			cfg_q.active_low       <= 1'b1;
			cfg_q.use_interrupt    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_DEBOUNCE:  cfg_q.debounce_latency <= cfg_wdata[LAT_W-1:0];
				CFG_HOLD_DOWN: cfg_q.hold_down_time   <= cfg_wdata[LAT_W-1:0];
				CFG_ACT_LOW:   cfg_q.active_low       <= cfg_wdata[0];
				CFG_USE_IRQ:   cfg_q.use_interrupt    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: design/bpc_core.sv
module bpc_core import bpc_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  item_t        item,
	input  cfg_t         cfg,
	output res_t         result,
	output core_status_t status
);

	phase_t                phase_q, phase_d;
	logic [TIME_BITS-1:0]  stamp_q, stamp_d;
	logic [TIME_BITS-1:0]  now_t;
	logic [TIME_BITS-1:0]  elapsed;
	logic                  pressed;
	logic                  settled;
	logic                  held_long;

	// Time stamp fitted to the internal time width
	assign now_t   = TIME_BITS'(item.now_ms);
	assign pressed = (item.pin_level == !cfg.active_low);

	// Zero stamp reads as no elapsed time
	assign elapsed   = (stamp_q == '0) ? '0 : (now_t - stamp_q);
	assign settled   = (elapsed > TIME_BITS'(cfg.debounce_latency));
	assign held_long = (elapsed > TIME_BITS'(cfg.hold_down_time));

	// Phase state register and stamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_STANDBY;
			stamp_q <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			stamp_q <= stamp_d;
		end
	end

	// Next phase and classification
	always_comb begin
		phase_d = phase_q;
		stamp_d = stamp_q;
		result  = RES_SKIP;
		if (item.func == FUNC_IRQ) begin
			// press edge only matters in standby
			if (phase_q == PH_STANDBY) begin
				phase_d = PH_DETECTING;
				stamp_d = now_t;
			end
		end else begin
			case (phase_q)
				PH_STANDBY: begin
					if (!cfg.use_interrupt && pressed) begin
						phase_d = PH_DETECTING;
						stamp_d = now_t;
						result  = RES_PUSHING;
					end
				end
				PH_DETECTING: begin
					if (settled && !pressed) begin
						phase_d = PH_WAITING;
						stamp_d = now_t;
						result  = held_long ? RES_LONG : RES_SHORT;
					end else begin
						result = RES_PUSHING;
					end
				end
				PH_WAITING: begin
					if (settled) begin
						phase_d = PH_STANDBY;
						stamp_d = '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign status.phase = phase_q;

endmodule

FILE: design/button_press_classifier_top.sv
// Button press classifier: debounce plus short/long press detection.
// Path: the input register holds an accepted item, the core classifies it, and the result register holds its result.
// Throughput: one item per cycle while the result side takes results; the phase/stamp update is the loop.
// Reset: pipeline empty, phase standby, stamp zero, registers at their
// defaults (debounce 50, hold-down 1000, active low, interrupt mode).
module button_press_classifier_top import bpc_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	bpc_item_if.sink              item,
	bpc_result_if.source          result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t         cfg;
	item_t        item_s1;
	logic         vld_s1;
	logic         vld_s2;
	res_t         res_s2;
	res_t         core_res;
	core_status_t core_st;
	logic         adv_s2;
	logic         adv_s1;

	bpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Pipeline flow: output stage frees when empty or taken
	assign adv_s2      = !vld_s2 || result.ready;
	assign adv_s1      = vld_s1 && adv_s2;
	assign item.ready  = !vld_s1 || adv_s2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item.ready) begin
			vld_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.func      <= item.func;
			item_s1.pin_level <= item.pin_level;
			item_s1.now_ms    <= item.now_ms;
		end
	end

	bpc_core #(.TIME_BITS(TIME_BITS)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv_s1),
		.item   (item_s1),
		.cfg    (cfg),
		.result (core_res),
		.status (core_st)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= core_res;
		end
	end

	assign result.valid        = vld_s2;
	assign result.press_result = res_s2;

`include "button_press_classifier_top_assert.svh"

	// A new result only appears after an item sat in the input stage
	`BPC_ASSERT_NOW(a_res_from_s1, vld_s2 && !$past(vld_s2), $past(vld_s1))
	// A completed press always leaves the block settling
	`BPC_ASSERT_NEXT(a_press_to_wait, adv_s1 && (core_res == RES_SHORT || core_res == RES_LONG), core_st.phase == PH_WAITING)
	// Interrupt items never report anything
	`BPC_ASSERT_NEXT(a_irq_skip, adv_s1 && item_s1.func == FUNC_IRQ, res_s2 == RES_SKIP)
	// Polling start only when interrupt mode is off
	`BPC_ASSERT_NOW(a_poll_start, adv_s1 && core_st.phase == PH_STANDBY && core_res == RES_PUSHING, !cfg.use_interrupt)

endmodule
